// ----- rtl/core/btm_pkg.sv -----
`default_nettype none

package btm_pkg;

  localparam int MaxWidthDefault   = 1024;
  localparam int MaxHeightDefault  = 1024;
  localparam int SampleBitsDefault = 16;

  localparam int CfgDataW     = 11;
  localparam int CfgIdxW      = 1;
  localparam int CfgSizeReset = 1024;
  localparam int SizeMin      = 2;

  localparam int ResultsMax = 3;
  localparam int PushW      = $clog2(ResultsMax + 1);
  localparam int QueueDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_reg_e;

  typedef logic [1:0] flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/btm_flag_line.sv -----
`default_nettype none

module btm_flag_line #(
  parameter int Depth = btm_pkg::MaxWidthDefault
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire btm_pkg::flags_t    wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr0_i,
  input  wire [$clog2(Depth)-1:0] raddr1_i,
  output btm_pkg::flags_t         rdata0_o,
  output btm_pkg::flags_t         rdata1_o
);

  btm_pkg::flags_t mem [Depth];
  btm_pkg::flags_t rd0_q;
  btm_pkg::flags_t rd1_q;

  // A read of the entry written in the same cycle returns the new flags.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd0_q <= (we_i && (waddr_i == raddr0_i)) ? wdata_i : mem[raddr0_i];
    rd1_q <= (we_i && (waddr_i == raddr1_i)) ? wdata_i : mem[raddr1_i];
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

`default_nettype wire

// ----- rtl/core/btm_result_queue.sv -----
`default_nettype none

module btm_result_queue #(
  parameter int EntryW = 23,
  parameter int Depth  = btm_pkg::QueueDepth
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire [btm_pkg::PushW-1:0]                 push_n_i,
  input  wire [btm_pkg::ResultsMax*EntryW-1:0]     push_data_i,
  input  wire                                      pop_i,
  output logic                                     valid_o,
  output logic [EntryW-1:0]                        data_o,
  output logic [$clog2(Depth+1)-1:0]               count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [EntryW-1:0] slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < btm_pkg::ResultsMax; i++) begin
      if (btm_pkg::PushW'(i) < push_n_i) begin
        slots_q[wr_ptr_q + PtrW'(i)] <= push_data_i[i*EntryW +: EntryW];
      end
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_n_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    count_d  = count_q + CntW'(push_n_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ----- rtl/core/blend_transition_mask.sv -----
// A mask bit enters the result queue when the item that completes it is accepted.
// Throughput: one item per cycle while out_stall_i is low and each item gives at most one
// mask bit; in the last row each item but the first gives two (three at the corner), so the
// single output port sets the pace. A four-entry result queue stalls the input when fewer
// than three entries are free. Reset clears the position counters and queue and sets both
// sizes to min(1024, MAX_*); the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module blend_transition_mask #(
  parameter int MAX_WIDTH   = btm_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT  = btm_pkg::MaxHeightDefault,
  parameter int SAMPLE_BITS = btm_pkg::SampleBitsDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [btm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [btm_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [SAMPLE_BITS-1:0]          height_a_i,
  input  wire [SAMPLE_BITS-1:0]          height_b_i,
  input  wire [SAMPLE_BITS-1:0]          blended_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           mask_bit_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   column_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]  row_o,
  output logic                           last_of_run_o,
  output logic                           frame_done_o
);

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int RowW   = $clog2(MAX_HEIGHT);
  localparam int EntryW = ColW + RowW + 3;
  localparam int QCntW  = $clog2(btm_pkg::QueueDepth + 1);
  localparam int SzW0   = ($clog2(MAX_WIDTH + 1) > btm_pkg::CfgDataW) ?
                          $clog2(MAX_WIDTH + 1) : btm_pkg::CfgDataW;
  localparam int SzW1   = ($clog2(MAX_HEIGHT + 1) > btm_pkg::CfgDataW) ?
                          $clog2(MAX_HEIGHT + 1) : btm_pkg::CfgDataW;
  localparam int WReset = (btm_pkg::CfgSizeReset > MAX_WIDTH) ?
                          MAX_WIDTH : btm_pkg::CfgSizeReset;
  localparam int HReset = (btm_pkg::CfgSizeReset > MAX_HEIGHT) ?
                          MAX_HEIGHT : btm_pkg::CfgSizeReset;
  localparam logic [ColW-1:0] ColMax   = ColW'(MAX_WIDTH - 1);
  localparam logic [QCntW-1:0] QStallAt = QCntW'(btm_pkg::QueueDepth - btm_pkg::ResultsMax);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_last_q, col_last_d;
  logic [RowW-1:0] row_last_q, row_last_d;
  btm_pkg::flags_t prev_q, left_q;

  logic [SzW0-1:0] wsize;
  logic [SzW1-1:0] hsize;

  logic            in_acc;
  logic            last_col, last_row;
  btm_pkg::flags_t cur, old_flags, right_flags, hn;
  logic [ColW-1:0] raddr1;
  logic            v0, v1, v2;
  logic            m0, m1;

  logic [btm_pkg::PushW-1:0]                 push_n;
  logic [btm_pkg::ResultsMax*EntryW-1:0]     push_data;
  logic [EntryW-1:0]                         head;
  logic [QCntW-1:0]                          q_count;
  logic                                      pop;

  function automatic logic mask_of(btm_pkg::flags_t p, btm_pkg::flags_t h,
                                   btm_pkg::flags_t v);
    mask_of = ((p & h & v) == 2'b00);
  endfunction

  // Sizes are clamped and stored as the last valid index.
  always_comb begin
    wsize      = SzW0'(cfg_data_i);
    hsize      = SzW1'(cfg_data_i);
    col_last_d = col_last_q;
    row_last_d = row_last_q;
    if (wsize < SzW0'(btm_pkg::SizeMin)) begin
      wsize = SzW0'(btm_pkg::SizeMin);
    end else if (wsize > SzW0'(MAX_WIDTH)) begin
      wsize = SzW0'(MAX_WIDTH);
    end
    if (hsize < SzW1'(btm_pkg::SizeMin)) begin
      hsize = SzW1'(btm_pkg::SizeMin);
    end else if (hsize > SzW1'(MAX_HEIGHT)) begin
      hsize = SzW1'(MAX_HEIGHT);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (btm_pkg::cfg_reg_e'(cfg_index_i))
        btm_pkg::CfgFrameWidth:  col_last_d = ColW'(wsize - SzW0'(1));
        btm_pkg::CfgFrameHeight: row_last_d = RowW'(hsize - SzW1'(1));
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign in_stall_o = (q_count > QStallAt);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cur      = {blended_i == height_b_i, blended_i == height_a_i};
    last_col = (col_q >= col_last_q);
    last_row = (row_q >= row_last_q);
    col_d    = col_q;
    row_d    = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    raddr1 = (col_d == ColMax) ? '0 : col_d + ColW'(1);
  end

  btm_flag_line #(
    .Depth (MAX_WIDTH)
  ) u_line (
    .clk_i    (clk_i),
    .we_i     (in_acc),
    .waddr_i  (col_q),
    .wdata_i  (cur),
    .raddr0_i (col_d),
    .raddr1_i (raddr1),
    .rdata0_o (old_flags),
    .rdata1_o (right_flags)
  );

  always_comb begin
    hn = last_col ? prev_q : right_flags;
    v0 = (row_q != '0);
    v1 = last_row && (col_q != '0);
    v2 = v1 && last_col;
    m0 = mask_of(old_flags, hn, cur);
    m1 = mask_of(left_q, cur, prev_q);
    if (!in_acc) begin
      push_n = '0;
    end else if (v2) begin
      push_n = btm_pkg::PushW'(3);
    end else if (v1) begin
      push_n = btm_pkg::PushW'(2);
    end else if (v0) begin
      push_n = btm_pkg::PushW'(1);
    end else begin
      push_n = '0;
    end
    push_data[0*EntryW +: EntryW] = {1'b0, !v1, row_q - RowW'(1), col_q, m0};
    push_data[1*EntryW +: EntryW] = {1'b0, !v2, row_q, col_q - ColW'(1), m1};
    push_data[2*EntryW +: EntryW] = {1'b1, 1'b1, row_q, col_q, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_last_q <= ColW'(WReset - 1);
      row_last_q <= RowW'(HReset - 1);
      prev_q     <= '0;
      left_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      col_last_q <= col_last_d;
      row_last_q <= row_last_d;
      if (in_acc) begin
        prev_q <= old_flags;
        left_q <= cur;
      end
    end
  end

  assign pop = out_valid_o && !out_stall_i;

  btm_result_queue #(
    .EntryW (EntryW),
    .Depth  (btm_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (q_count)
  );

  assign mask_bit_o    = head[0];
  assign column_o      = head[1 +: ColW];
  assign row_o         = head[1 + ColW +: RowW];
  assign last_of_run_o = head[1 + ColW + RowW];
  assign frame_done_o  = head[2 + ColW + RowW];

endmodule

`default_nettype wire
